[src/base64_stream_codec_defines.svh]
`ifndef BASE64_STREAM_CODEC_DEFINES_SVH
`define BASE64_STREAM_CODEC_DEFINES_SVH

// plain check on every edge outside reset
`define B64_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// antecedent now, consequent in the next cycle
`define B64_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/b64_pkg.sv]
package b64_pkg;

    localparam int GROUPS_PER_LINE_DEF = 16;
    localparam int JOB_MAX = 5;
    localparam int JOB_CNT_W = 3;
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    localparam logic [7:0] CHAR_PAD = 8'h3D;
    localparam logic [7:0] CHAR_NL = 8'h0A;
    localparam logic [6:0] IDX_PAD = 7'd64;
    localparam logic [6:0] IDX_NONE = 7'd65;

    localparam logic [1:0] REG_DECODE_MODE = 2'd0;
    localparam logic [1:0] REG_URL_SAFE = 2'd1;
    localparam logic [1:0] REG_WRAP_LINES = 2'd2;

    typedef logic [JOB_MAX-1:0][7:0] job_bytes_t;

    typedef struct packed {
        job_bytes_t bytes;
        logic [JOB_CNT_W-1:0] count;
    } job_t;

    typedef struct packed {
        logic decode_mode;
        logic url_safe;
        logic wrap_lines;
    } cfg_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    function automatic logic [7:0] alpha_char(input logic [5:0] idx, input logic url);
        logic [7:0] i8;
        i8 = {2'b00, idx};
        if (idx < 6'd26) return 8'h41 + i8;
        else if (idx < 6'd52) return 8'h61 + i8 - 8'd26;
        else if (idx < 6'd62) return 8'h30 + i8 - 8'd52;
        else if (idx == 6'd62) return url ? 8'h2D : 8'h2B;
        else return url ? 8'h5F : 8'h2F;
    endfunction

    function automatic logic [6:0] alpha_index(input logic [7:0] c, input logic url);
        logic [7:0] d;
        d = 8'd0;
        if (c >= 8'h41 && c <= 8'h5A) begin
            d = c - 8'h41;
            return d[6:0];
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            d = c - 8'h61 + 8'd26;
            return d[6:0];
        end else if (c >= 8'h30 && c <= 8'h39) begin
            d = c - 8'h30 + 8'd52;
            return d[6:0];
        end else if (c == (url ? 8'h2D : 8'h2B)) return 7'd62;
        else if (c == (url ? 8'h5F : 8'h2F)) return 7'd63;
        else if (c == CHAR_PAD) return IDX_PAD;
        else return IDX_NONE;
    endfunction

endpackage

[src/b64_front.sv]
module b64_front
    import b64_pkg::*;
#(
    parameter int GROUPS_PER_LINE = GROUPS_PER_LINE_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  cfg_t       cfg,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic       s_tlast,
    input  logic       q_full,
    output logic       q_push,
    output job_t       push_job
);

    localparam int LGC_W = (GROUPS_PER_LINE > 1) ? $clog2(GROUPS_PER_LINE) : 1;
    localparam logic [LGC_W-1:0] LGC_MAX = LGC_W'(GROUPS_PER_LINE - 1);

    logic [23:0]      group_bits_reg, group_bits_next;
    logic [1:0]       fill_count_reg, fill_count_next;
    logic [LGC_W-1:0] line_count_reg, line_count_next;
    logic             any_group_reg, any_group_next;
    logic             stopped_reg, stopped_next;
    logic             accept;
    job_t             job;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign q_push   = accept && (job.count != '0);
    assign push_job = job;

    always_comb begin
        logic [1:0]  enc_pos;
        logic [1:0]  enc_fill;
        logic [23:0] enc_gb;
        logic        enc_nl;
        logic [7:0]  ch [4];
        logic [6:0]  dec_idx;
        logic [23:0] dec_gb;
        logic [2:0]  dec_fc;
        logic [23:0] flush_v;

        group_bits_next = group_bits_reg;
        fill_count_next = fill_count_reg;
        line_count_next = line_count_reg;
        any_group_next  = any_group_reg;
        stopped_next    = stopped_reg;
        job             = '0;
        enc_pos  = '0;
        enc_fill = '0;
        enc_gb   = '0;
        enc_nl   = 1'b0;
        for (int i = 0; i < 4; i++) ch[i] = CHAR_PAD;
        dec_idx  = IDX_NONE;
        dec_gb   = '0;
        dec_fc   = '0;
        flush_v  = '0;

        if (!cfg.decode_mode) begin
            enc_pos = (fill_count_reg == 2'd3) ? 2'd2 : fill_count_reg;
            case (enc_pos)
                2'd0:    enc_gb = group_bits_reg | {s_tdata, 16'h0000};
                2'd1:    enc_gb = group_bits_reg | {8'h00, s_tdata, 8'h00};
                default: enc_gb = group_bits_reg | {16'h0000, s_tdata};
            endcase
            enc_fill = enc_pos + 2'd1;
            group_bits_next = enc_gb;
            fill_count_next = enc_fill;
            if (enc_fill == 2'd3 || s_tlast) begin
                if (cfg.wrap_lines) begin
                    enc_nl = any_group_reg && (line_count_reg == '0);
                    line_count_next = (line_count_reg == LGC_MAX) ? '0
                                                                  : line_count_reg + 1'b1;
                    any_group_next = 1'b1;
                end
                for (int i = 0; i < 4; i++) begin
                    if (i <= int'(enc_fill))
                        ch[i] = alpha_char(enc_gb[23 - 6*i -: 6], cfg.url_safe);
                end
                if (enc_nl) begin
                    job.bytes[0] = CHAR_NL;
                    for (int i = 0; i < 4; i++) job.bytes[i+1] = ch[i];
                    job.count = JOB_CNT_W'(5);
                end else begin
                    for (int i = 0; i < 4; i++) job.bytes[i] = ch[i];
                    job.count = JOB_CNT_W'(4);
                end
                group_bits_next = '0;
                fill_count_next = '0;
            end
        end else if (!stopped_reg) begin
            dec_idx = alpha_index(s_tdata, cfg.url_safe);
            dec_gb  = group_bits_reg;
            dec_fc  = {1'b0, fill_count_reg};
            if (dec_idx < IDX_PAD) begin
                dec_gb = {group_bits_reg[17:0], dec_idx[5:0]};
                dec_fc = {1'b0, fill_count_reg} + 3'd1;
            end
            if (dec_fc == 3'd4) begin
                job.bytes[0] = dec_gb[23:16];
                job.bytes[1] = dec_gb[15:8];
                job.bytes[2] = dec_gb[7:0];
                job.count = JOB_CNT_W'(3);
                group_bits_next = '0;
                fill_count_next = '0;
            end else begin
                group_bits_next = dec_gb;
                fill_count_next = dec_fc[1:0];
                if (dec_idx == IDX_PAD || s_tlast) begin
                    // left-align the pending codes, then take whole bytes
                    case (dec_fc[1:0])
                        2'd0:    flush_v = '0;
                        2'd1:    flush_v = {dec_gb[5:0], 18'h0};
                        2'd2:    flush_v = {dec_gb[11:0], 12'h0};
                        default: flush_v = {dec_gb[17:0], 6'h0};
                    endcase
                    job.bytes[0] = flush_v[23:16];
                    job.bytes[1] = flush_v[15:8];
                    job.count = (dec_fc[1:0] >= 2'd2) ? JOB_CNT_W'(dec_fc[1:0] - 2'd1) : '0;
                    group_bits_next = '0;
                    fill_count_next = '0;
                end
                if (dec_idx == IDX_PAD) stopped_next = 1'b1;
            end
        end

        if (s_tlast) begin
            group_bits_next = '0;
            fill_count_next = '0;
            line_count_next = '0;
            any_group_next  = 1'b0;
            stopped_next    = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            group_bits_reg <= '0;
            fill_count_reg <= '0;
            line_count_reg <= '0;
            any_group_reg  <= 1'b0;
            stopped_reg    <= 1'b0;
        end else if (accept) begin
            group_bits_reg <= group_bits_next;
            fill_count_reg <= fill_count_next;
            line_count_reg <= line_count_next;
            any_group_reg  <= any_group_next;
            stopped_reg    <= stopped_next;
        end
    end

endmodule

[src/b64_queue.sv]
module b64_queue
    import b64_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  job_t    push_job,
    input  logic    pop,
    output job_t    head_job,
    output q_stat_t stat
);

    job_t              mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   count_reg, count_next;
    logic              do_push, do_pop;

    assign stat.full  = (count_reg == (QPTR_W+1)'(QDEPTH));
    assign stat.empty = (count_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign head_job   = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (do_push) mem[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[src/b64_back.sv]
module b64_back
    import b64_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  job_t       head_job,
    input  q_stat_t    q_stat,
    output logic       pop,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,
    output logic       m_tlast
);

    job_bytes_t           data_reg, data_next;
    logic [JOB_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 take;

    assign m_tvalid = (cnt_reg != '0);
    assign m_tdata  = data_reg[0];
    assign m_tlast  = (cnt_reg == JOB_CNT_W'(1));
    assign take     = m_tvalid && m_tready;
    // load when idle, or reload as the last word of the current job leaves
    assign pop      = !q_stat.empty && (!m_tvalid || (m_tlast && m_tready));

    always_comb begin
        data_next = data_reg;
        cnt_next  = cnt_reg;
        if (pop) begin
            data_next = head_job.bytes;
            cnt_next  = head_job.count;
        end else if (take) begin
            data_next = job_bytes_t'(data_reg >> 8);
            cnt_next  = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

endmodule

[src/base64_stream_codec.sv]
// Base64 encoder and decoder on a byte stream. One byte or character enters per word
// on the s_ side, tlast marking stream end; results leave one byte per word on the m_
// side, tlast marking the last result of an input word. A word is accepted in any cycle
// in which the four-entry job queue has room; each accepted word becomes at most one job
// of up to five output words. The output port moves one word per cycle while m_tready
// is high; encoding gives 4 output words per 3 input bytes (5 when a newline is
// inserted), and decoding keeps pace, as four characters give only three output words.
// Configuration is written through cfg_we/cfg_index/cfg_wdata: 0 decode_mode,
// 1 url_safe, 2 wrap_lines.
`include "base64_stream_codec_defines.svh"

module base64_stream_codec
    import b64_pkg::*;
#(
    parameter int GROUPS_PER_LINE = GROUPS_PER_LINE_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [0:0] cfg_wdata,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // data_byte
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // out_byte
    output logic       m_tlast
);

    cfg_t    cfg_reg;
    logic    q_push;
    logic    q_pop;
    job_t    push_job;
    job_t    head_job;
    q_stat_t q_stat;
    logic    job_cnt_ok;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_DECODE_MODE: cfg_reg.decode_mode <= cfg_wdata[0];
                REG_URL_SAFE:    cfg_reg.url_safe    <= cfg_wdata[0];
                REG_WRAP_LINES:  cfg_reg.wrap_lines  <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    b64_front #(
        .GROUPS_PER_LINE(GROUPS_PER_LINE)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (q_stat.full),
        .q_push   (q_push),
        .push_job (push_job)
    );

    b64_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_job (push_job),
        .pop      (q_pop),
        .head_job (head_job),
        .stat     (q_stat)
    );

    b64_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head_job (head_job),
        .q_stat   (q_stat),
        .pop      (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    assign job_cnt_ok = (push_job.count != '0) && (push_job.count <= JOB_CNT_W'(JOB_MAX));

    `B64_ASSERT(a_no_overflow, q_push |-> !q_stat.full, "job pushed into a full queue")
    `B64_ASSERT(a_job_count, q_push |-> job_cnt_ok, "job word count out of range")
    `B64_ASSERT_NEXT(a_out_load, !m_tvalid && !q_stat.empty, m_tvalid, "queued job not loaded")

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import b64_pkg::*;

    localparam int DRAIN_CYCLES   = 40;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int STREAM_WORDS   = 120;

    // expected output words and a bit-true copy of the codec state
    class codec_scoreboard;
        logic        decode_mode;
        logic        url_safe;
        logic        wrap_lines;
        logic [23:0] group_bits;
        int unsigned fill_count;
        int unsigned line_groups;
        bit          any_group_done;
        bit          decode_stopped;
        logic [7:0]  item_bytes[$];
        logic [8:0]  expected_words[$];   // {out_last, out_byte}
        int          errors;

        function new();
            decode_mode = 1'b0;
            url_safe = 1'b0;
            wrap_lines = 1'b0;
            errors = 0;
            clear_stream();
        endfunction

        function void clear_stream();
            group_bits = '0;
            fill_count = 0;
            line_groups = 0;
            any_group_done = 1'b0;
            decode_stopped = 1'b0;
        endfunction

        function void set_reg(logic [1:0] idx, logic val);
            case (idx)
                REG_DECODE_MODE: decode_mode = val;
                REG_URL_SAFE:    url_safe = val;
                REG_WRAP_LINES:  wrap_lines = val;
                default: ;
            endcase
        endfunction

        function logic [7:0] char_of(int unsigned code);
            string letters;
            letters = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
            if (url_safe && code == 62) return "-";
            if (url_safe && code == 63) return "_";
            return letters[code];
        endfunction

        function int unsigned code_of(logic [7:0] c);
            for (int k = 0; k < 64; k++) begin
                if (char_of(k) == c) return k;
            end
            if (c == CHAR_PAD) return IDX_PAD;
            return IDX_NONE;
        endfunction

        function void encode_group(int unsigned nbytes);
            if (wrap_lines) begin
                if (any_group_done && line_groups == 0) item_bytes.push_back(CHAR_NL);
                line_groups = (line_groups + 1) % GROUPS_PER_LINE_DEF;
                any_group_done = 1'b1;
            end
            for (int unsigned i = 0; i < 4; i++) begin
                if (i <= nbytes)
                    item_bytes.push_back(char_of(int'((group_bits >> (18 - 6 * i)) & 24'h3f)));
                else
                    item_bytes.push_back(CHAR_PAD);
            end
            group_bits = '0;
            fill_count = 0;
        endfunction

        function void flush_decoded();
            logic [31:0] v;
            v = ({8'd0, group_bits} << (6 * (4 - fill_count))) & 32'h00ff_ffff;
            if (fill_count >= 2) begin
                for (int unsigned k = 0; k + 1 < fill_count; k++)
                    item_bytes.push_back(v[23 - 8 * k -: 8]);
            end
            group_bits = '0;
            fill_count = 0;
        endfunction

        function void note_input(logic [7:0] b, logic l);
            int unsigned pos;
            int unsigned code;
            item_bytes.delete();
            if (!decode_mode) begin
                // a third byte already held (left by decode) is merged with the new one
                pos = (fill_count > 2) ? 2 : fill_count;
                group_bits = group_bits | ({16'd0, b} << (16 - 8 * pos));
                fill_count = pos + 1;
                if (fill_count == 3)
                    encode_group(3);
                else if (l)
                    encode_group(fill_count);
            end else if (!decode_stopped) begin
                code = code_of(b);
                if (code == IDX_PAD) begin
                    flush_decoded();
                    decode_stopped = 1'b1;
                end else if (code < 64) begin
                    group_bits = {group_bits[17:0], 6'(code)};
                    fill_count++;
                    if (fill_count >= 4) begin
                        item_bytes.push_back(group_bits[23:16]);
                        item_bytes.push_back(group_bits[15:8]);
                        item_bytes.push_back(group_bits[7:0]);
                        group_bits = '0;
                        fill_count = 0;
                    end
                end
                if (l) flush_decoded();
            end
            if (l) clear_stream();
            foreach (item_bytes[i])
                expected_words.push_back({i == item_bytes.size() - 1, item_bytes[i]});
        endfunction

        function void check_result(logic [7:0] b, logic l);
            logic [8:0] e;
            if (expected_words.size() == 0) begin
                $display("%0t: unexpected word, expected none, actual out_byte=%h out_last=%b",
                         $time, b, l);
                errors++;
                return;
            end
            e = expected_words.pop_front();
            if (e[7:0] !== b) begin
                $display("%0t: out_byte differs, expected %h, actual %h", $time, e[7:0], b);
                errors++;
            end
            if (e[8] !== l) begin
                $display("%0t: out_last differs, expected %b, actual %b", $time, e[8], l);
                errors++;
            end
        endfunction

        function int pending();
            return expected_words.size();
        endfunction
    endclass

    logic       aclk;
    logic       aresetn;
    logic       cfg_we;
    logic [1:0] cfg_index;
    logic [0:0] cfg_wdata;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic       s_tlast;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;
    logic       m_tlast;

    codec_scoreboard sb = new();
    bit s_idle_en;
    bit m_idle_en;
    int stream_words;
    int idle_cycles;

    base64_stream_codec dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    always @(negedge aclk) begin
        m_tready <= m_idle_en ? ($urandom_range(0, 99) >= 33) : 1'b1;
    end

    // both handshakes are taken here so the order within an edge never matters
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) sb.note_input(s_tdata, s_tlast);
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata, m_tlast);
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    task automatic send_word(input logic [7:0] b, input logic l);
        @(negedge aclk);
        while (s_idle_en && $urandom_range(0, 99) < 33) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tlast <= l;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        stream_words++;
    endtask

    task automatic wait_idle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(negedge aclk);
        // quiet cycles before the settings change
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        sb.set_reg(idx, val);
    endtask

    task automatic set_config(input logic mode, input logic url, input logic wrap);
        wait_idle();
        cfg_write(REG_DECODE_MODE, mode);
        cfg_write(REG_URL_SAFE, url);
        cfg_write(REG_WRAP_LINES, wrap);
        cfg_we <= 1'b0;
    endtask

    task automatic encode_stream(input int n, input bit with_end);
        for (int i = 0; i < n; i++)
            send_word(8'($urandom_range(0, 255)), with_end && i == n - 1);
    endtask

    // mostly alphabet characters, some padding and arbitrary noise
    task automatic decode_stream(input int n, input bit with_end);
        int r;
        logic [7:0] ch;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 80)
                ch = sb.char_of($urandom_range(0, 63));
            else if (r < 85)
                ch = CHAR_PAD;
            else
                ch = 8'($urandom_range(0, 255));
            send_word(ch, with_end && i == n - 1);
        end
    endtask

    initial begin
        int phase_no;
        logic mode;
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        m_tready = 1'b0;
        s_idle_en = 1'b1;
        m_idle_en = 1'b1;
        stream_words = 0;
        idle_cycles = 0;
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;

        // encode: full group, two-byte and one-byte tails
        set_config(1'b0, 1'b0, 1'b0);
        send_word(8'h00, 1'b0);
        send_word(8'hff, 1'b0);
        send_word(8'h00, 1'b0);
        send_word(8'hfb, 1'b0);
        send_word(8'hff, 1'b1);
        send_word(8'hff, 1'b1);
        // url-safe characters for codes 62 and 63
        set_config(1'b0, 1'b1, 1'b0);
        send_word(8'hfb, 1'b0);
        send_word(8'hff, 1'b0);
        send_word(8'hbf, 1'b1);
        // decode with skipped noise and a two-code flush
        set_config(1'b1, 1'b0, 1'b0);
        send_word("/", 1'b0);
        send_word("+", 1'b0);
        send_word("9", 1'b0);
        send_word("a", 1'b0);
        send_word("%", 1'b0);
        send_word("Q", 1'b0);
        send_word("Q", 1'b1);
        // padding after a single code, then characters that are ignored
        send_word("Q", 1'b0);
        send_word("=", 1'b0);
        send_word("A", 1'b0);
        send_word("B", 1'b1);
        // url-safe decode: '+' is not in the alphabet
        set_config(1'b1, 1'b1, 1'b0);
        send_word("+", 1'b0);
        send_word("-", 1'b0);
        send_word("_", 1'b0);
        send_word("A", 1'b0);
        send_word("z", 1'b1);

        phase_no = 0;
        while (stream_words < STREAM_WORDS) begin
            s_idle_en = !(phase_no >= 3 && phase_no <= 5);
            m_idle_en = s_idle_en;
            if (phase_no == 0) begin
                // long enough to wrap past one full line
                set_config(1'b0, 1'($urandom_range(0, 1)), 1'b1);
                encode_stream(55, 1'b1);
            end else begin
                // streams left open carry their state into the next setting
                mode = 1'($urandom_range(0, 1));
                set_config(mode, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                if (mode)
                    decode_stream($urandom_range(1, 12), $urandom_range(0, 3) != 0);
                else
                    encode_stream($urandom_range(1, 12), $urandom_range(0, 3) != 0);
            end
            phase_no++;
        end

        s_idle_en = 1'b1;
        m_idle_en = 1'b1;
        wait_idle();
        if (sb.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

[filelist.f]
+incdir+src
src/b64_pkg.sv
src/b64_front.sv
src/b64_queue.sv
src/b64_back.sv
src/base64_stream_codec.sv
test/testbench.sv
